@@ src/ofr_pkg.sv @@
// ----------------------------------------------------------------------------
// ofr_pkg: shared types, constants and tables
// Widths, CORDIC arctangent table and mode codes for the frame rotation block.
// ----------------------------------------------------------------------------
`default_nettype none
package ofr_pkg;
    localparam int VEC_WIDTH    = 32;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_WIDTH   = 33;   // cordic working width, holds 2^30 margin
    localparam int ELEM_WIDTH   = 32;   // trig values and matrix elements, q2.30
    localparam int ACC_WIDTH    = VEC_WIDTH + ELEM_WIDTH + 4;
    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [ELEM_WIDTH-1:0] ONE_Q30 = 32'sd1073741824;

    typedef enum logic [1:0] {
        ACT_TO_LOCAL   = 2'd0,
        ACT_FROM_LOCAL = 2'd1,
        ACT_TO_LHLV    = 2'd2,
        ACT_FROM_LHLV  = 2'd3
    } action_t;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;

    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] r;
        case (k)
            0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
            3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
            9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
           12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
           15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
           18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
           21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
           24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
           27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
           default: r = 32'h0;
        endcase
        return r;
    endfunction

    // q30 product, rounded half up
    function automatic elem_t mulq(input elem_t a, input elem_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return elem_t'(p >>> 30);
    endfunction

    function automatic elem_t clamp_elem(input logic signed [ELEM_WIDTH+1:0] v);
        elem_t r;
        if (v > (ELEM_WIDTH+2)'(ONE_Q30))
            r = ONE_Q30;
        else if (v < -(ELEM_WIDTH+2)'(ONE_Q30))
            r = -ONE_Q30;
        else
            r = elem_t'(v);
        return r;
    endfunction
endpackage
`default_nettype wire

@@ src/ofr_cordic.sv @@
// ----------------------------------------------------------------------------
// ofr_cordic: pipelined sine and cosine
// Thirty rotation steps, two per register stage, quadrant fold and clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module ofr_cordic
    import ofr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [ANGLE_WIDTH-1:0] angle,
    output elem_t                       cos_out,
    output elem_t                       sin_out
);
    localparam int STAGES = CORDIC_STEPS / 2;

    logic signed [TRIG_WIDTH-1:0] x_reg [STAGES+1];
    logic signed [TRIG_WIDTH-1:0] y_reg [STAGES+1];
    logic signed [31:0]           z_reg [STAGES+1];
    logic [1:0]                   q_reg [STAGES+1];
    logic [31:0]                  a_full;

    assign a_full = {angle, (32-ANGLE_WIDTH)'(0)};

    // stage zero: load gain and residual angle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({2'b00, a_full[29:0]});
            q_reg[0] <= a_full[31:30];
        end
    end

    // two rotations per stage
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic signed [TRIG_WIDTH-1:0] x1, y1, x2, y2;
        logic signed [31:0]           z1, z2;
        always_comb
        begin
            if (z_reg[s] >= 0)
            begin
                x1 = x_reg[s] - (y_reg[s] >>> (2*s));
                y1 = y_reg[s] + (x_reg[s] >>> (2*s));
                z1 = z_reg[s] - $signed(atan_turn(2*s));
            end
            else
            begin
                x1 = x_reg[s] + (y_reg[s] >>> (2*s));
                y1 = y_reg[s] - (x_reg[s] >>> (2*s));
                z1 = z_reg[s] + $signed(atan_turn(2*s));
            end
            if (z1 >= 0)
            begin
                x2 = x1 - (y1 >>> (2*s+1));
                y2 = y1 + (x1 >>> (2*s+1));
                z2 = z1 - $signed(atan_turn(2*s+1));
            end
            else
            begin
                x2 = x1 + (y1 >>> (2*s+1));
                y2 = y1 - (x1 >>> (2*s+1));
                z2 = z1 + $signed(atan_turn(2*s+1));
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s+1] <= x2;
                y_reg[s+1] <= y2;
                z_reg[s+1] <= z2;
                q_reg[s+1] <= q_reg[s];
            end
        end
    end

    // clamp and quadrant fold
    elem_t xc, yc;
    always_comb
    begin
        xc = clamp_elem((ELEM_WIDTH+2)'(x_reg[STAGES]));
        yc = clamp_elem((ELEM_WIDTH+2)'(y_reg[STAGES]));
        case (q_reg[STAGES])
            2'd0:    begin cos_out = xc;  sin_out = yc;  end
            2'd1:    begin cos_out = -yc; sin_out = xc;  end
            2'd2:    begin cos_out = -xc; sin_out = -yc; end
            default: begin cos_out = yc;  sin_out = -xc; end
        endcase
    end
endmodule
`default_nettype wire

@@ src/orbital_frame_rotation_top.sv @@
// ----------------------------------------------------------------------------
// orbital_frame_rotation_top: 3-1-3 inertial / orbit frame vector rotation
// Pipelined trig, matrix build and matrix-vector product with saturation.
// ----------------------------------------------------------------------------
// an item passes 16 cordic register stages plus 7 matrix, product, sum,
//   permutation and saturation stages on its way to the result register;
//   throughput one item per clock, busy is 0
// the receiver cannot stall, so the pipeline always advances
// reset clears the valid bits only; payload registers are not reset
`default_nettype none
module orbital_frame_rotation_top
    import ofr_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   action,
    input  wire logic signed [VEC_WIDTH-1:0]  vec_x,
    input  wire logic signed [VEC_WIDTH-1:0]  vec_y,
    input  wire logic signed [VEC_WIDTH-1:0]  vec_z,
    input  wire logic [ANGLE_WIDTH-1:0]       inclination,
    input  wire logic [ANGLE_WIDTH-1:0]       node,
    input  wire logic [ANGLE_WIDTH-1:0]       true_anomaly,
    input  wire logic [ANGLE_WIDTH-1:0]       periapsis_arg,
    output logic                              done,
    output logic signed [VEC_WIDTH-1:0]       out_x,
    output logic signed [VEC_WIDTH-1:0]       out_y,
    output logic signed [VEC_WIDTH-1:0]       out_z,
    output logic                              saturated
);
    // trig outputs are ready after the edge that loads the last cordic stage
    localparam int TRIG_LAT = CORDIC_STEPS / 2;
    localparam int LAT      = TRIG_LAT + 8;
    localparam int VW1      = VEC_WIDTH + 1;

    logic [LAT-1:0] valid_reg;
    logic           en;
    assign en   = 1'b1;
    assign busy = 1'b0;

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], start};
    end

    // trig units
    logic [ANGLE_WIDTH-1:0] phase;
    assign phase = periapsis_arg + true_anomaly;
    elem_t ci, si, co, so, cp, sp;
    ofr_cordic u_cord_i (.clk, .en, .angle(inclination), .cos_out(ci), .sin_out(si));
    ofr_cordic u_cord_o (.clk, .en, .angle(node),        .cos_out(co), .sin_out(so));
    ofr_cordic u_cord_p (.clk, .en, .angle(phase),       .cos_out(cp), .sin_out(sp));

    // vector and action delay line, with lhlv input permutation
    logic signed [VW1-1:0] w_reg [LAT][3];
    logic [1:0]            act_reg [LAT];
    always_ff @(posedge clk)
    begin
        act_reg[0] <= action;
        if (action_t'(action) == ACT_FROM_LHLV)
        begin
            w_reg[0][0] <= -VW1'(vec_z);
            w_reg[0][1] <= VW1'(vec_x);
            w_reg[0][2] <= -VW1'(vec_y);
        end
        else
        begin
            w_reg[0][0] <= VW1'(vec_x);
            w_reg[0][1] <= VW1'(vec_y);
            w_reg[0][2] <= VW1'(vec_z);
        end
        for (int i = 1; i < LAT; i++)
        begin
            act_reg[i] <= act_reg[i-1];
            w_reg[i]   <= w_reg[i-1];
        end
    end

    // matrix stage a: register trig, form node times inclination products
    elem_t ci_a, si_a, co_a, so_a, cp_a, sp_a, soci_a, coci_a;
    always_ff @(posedge clk)
    begin
        ci_a <= ci; si_a <= si; co_a <= co; so_a <= so; cp_a <= cp; sp_a <= sp;
        soci_a <= mulq(so, ci);
        coci_a <= mulq(co, ci);
    end

    // matrix stage b: products
    elem_t p_reg [12];
    elem_t ci_b;
    always_ff @(posedge clk)
    begin
        p_reg[0]  <= mulq(cp_a, co_a);
        p_reg[1]  <= mulq(soci_a, sp_a);
        p_reg[2]  <= mulq(cp_a, so_a);
        p_reg[3]  <= mulq(coci_a, sp_a);
        p_reg[4]  <= mulq(si_a, sp_a);
        p_reg[5]  <= mulq(sp_a, co_a);
        p_reg[6]  <= mulq(soci_a, cp_a);
        p_reg[7]  <= mulq(sp_a, so_a);
        p_reg[8]  <= mulq(coci_a, cp_a);
        p_reg[9]  <= mulq(si_a, cp_a);
        p_reg[10] <= mulq(si_a, so_a);
        p_reg[11] <= mulq(si_a, co_a);
        ci_b      <= ci_a;
    end

    // matrix stage c: combine, clamp, transpose select
    localparam int EW2 = ELEM_WIDTH + 2;
    elem_t m_reg [3][3];
    always_ff @(posedge clk)
    begin
        elem_t m [3][3];
        m[0][0] = clamp_elem(EW2'(p_reg[0]) - EW2'(p_reg[1]));
        m[0][1] = clamp_elem(EW2'(p_reg[2]) + EW2'(p_reg[3]));
        m[0][2] = clamp_elem(EW2'(p_reg[4]));
        m[1][0] = clamp_elem(-EW2'(p_reg[5]) - EW2'(p_reg[6]));
        m[1][1] = clamp_elem(-EW2'(p_reg[7]) + EW2'(p_reg[8]));
        m[1][2] = clamp_elem(EW2'(p_reg[9]));
        m[2][0] = clamp_elem(EW2'(p_reg[10]));
        m[2][1] = clamp_elem(-EW2'(p_reg[11]));
        m[2][2] = clamp_elem(EW2'(ci_b));
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                m_reg[a][b] <= act_reg[TRIG_LAT+2][0] ? m[b][a] : m[a][b];
    end

    // product stage: nine element-by-component products, exact
    localparam int PW = VW1 + ELEM_WIDTH;
    logic signed [PW-1:0] prod_reg [3][3];
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                prod_reg[a][b] <= PW'(m_reg[a][b]) * PW'(w_reg[TRIG_LAT+3][b]);
    end

    // sum stage, rounded shift
    localparam int SW = PW + 2;
    localparam int RW = SW - 30;
    logic signed [RW-1:0] r_reg [3];
    always_ff @(posedge clk)
    begin
        logic signed [SW-1:0] s;
        for (int a = 0; a < 3; a++)
        begin
            s = SW'(prod_reg[a][0]) + SW'(prod_reg[a][1]) + SW'(prod_reg[a][2])
                + SW'(64'sd536870912);
            r_reg[a] <= RW'(s >>> 30);
        end
    end

    // output permutation for lhlv
    logic signed [RW:0] o_reg [3];
    always_ff @(posedge clk)
    begin
        if (action_t'(act_reg[TRIG_LAT+5]) == ACT_TO_LHLV)
        begin
            o_reg[0] <= (RW+1)'(r_reg[1]);
            o_reg[1] <= -(RW+1)'(r_reg[2]);
            o_reg[2] <= -(RW+1)'(r_reg[0]);
        end
        else
            for (int a = 0; a < 3; a++)
                o_reg[a] <= (RW+1)'(r_reg[a]);
    end

    // saturation and output register
    localparam logic signed [RW:0] VMAX = (RW+1)'({1'b0, {(VEC_WIDTH-1){1'b1}}});
    localparam logic signed [RW:0] VMIN = -VMAX - (RW+1)'(1);
    logic signed [VEC_WIDTH-1:0] res_reg [3];
    logic                        sat_reg;
    always_ff @(posedge clk)
    begin
        logic sat;
        sat = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (o_reg[a] > VMAX)
            begin
                res_reg[a] <= VMAX[VEC_WIDTH-1:0];
                sat = 1'b1;
            end
            else if (o_reg[a] < VMIN)
            begin
                res_reg[a] <= VMIN[VEC_WIDTH-1:0];
                sat = 1'b1;
            end
            else
                res_reg[a] <= o_reg[a][VEC_WIDTH-1:0];
        end
        sat_reg <= sat;
    end

    assign done      = valid_reg[LAT-1];
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign saturated = sat_reg;
endmodule
`default_nettype wire

@@ test/ofr_checker.sv @@
// ----------------------------------------------------------------------------
// ofr_checker: result predictor and comparator for the frame rotation block
// Watches accepted items, builds the 3-1-3 rotation from a fixed CORDIC of
// its own, and compares every result against the oldest expected vector.
// ----------------------------------------------------------------------------
`default_nettype none
module ofr_checker
    import ofr_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [1:0]                  action,
    input  wire logic signed [VEC_WIDTH-1:0] vec_x,
    input  wire logic signed [VEC_WIDTH-1:0] vec_y,
    input  wire logic signed [VEC_WIDTH-1:0] vec_z,
    input  wire logic [ANGLE_WIDTH-1:0]      inclination,
    input  wire logic [ANGLE_WIDTH-1:0]      node,
    input  wire logic [ANGLE_WIDTH-1:0]      true_anomaly,
    input  wire logic [ANGLE_WIDTH-1:0]      periapsis_arg,
    input  wire logic                        done,
    input  wire logic signed [VEC_WIDTH-1:0] out_x,
    input  wire logic signed [VEC_WIDTH-1:0] out_y,
    input  wire logic signed [VEC_WIDTH-1:0] out_z,
    input  wire logic                        saturated,
    output int                               mismatches,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT_Q30 = 64'sd1 << 30;
    localparam longint HALF_Q30 = 64'sd1 << 29;

    // arctangent of 2^-k in 2^-32 turn units
    localparam longint ARC_TURNS [0:29] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    typedef struct {
        logic signed [VEC_WIDTH-1:0] x;
        logic signed [VEC_WIDTH-1:0] y;
        logic signed [VEC_WIDTH-1:0] z;
        logic                        sat;
    } rotated_vec_t;

    rotated_vec_t rotated_q[$];

    function automatic longint unit_clip(input longint v);
        if (v > UNIT_Q30)
            return UNIT_Q30;
        if (v < -UNIT_Q30)
            return -UNIT_Q30;
        return v;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + HALF_Q30) >>> 30;
    endfunction

    // cos and sin of a binary angle, q2.30
    function automatic void sin_cos(input logic [ANGLE_WIDTH-1:0] ang,
                                    output longint c, output longint s);
        logic [31:0] turn;
        longint      cx, sy, z, dx, dy;
        turn = {ang, 16'h0};
        z    = longint'(turn[29:0]);
        cx   = 652032874;
        sy   = 0;
        for (int k = 0; k < 30; k++)
        begin
            dx = sy >>> k;
            dy = cx >>> k;
            if (z >= 0)
            begin
                cx -= dx; sy += dy; z -= ARC_TURNS[k];
            end
            else
            begin
                cx += dx; sy -= dy; z += ARC_TURNS[k];
            end
        end
        cx = unit_clip(cx);
        sy = unit_clip(sy);
        case (turn[31:30])
            2'd0: begin c = cx;  s = sy;  end
            2'd1: begin c = -sy; s = cx;  end
            2'd2: begin c = -cx; s = -sy; end
            default: begin c = sy; s = -cx; end
        endcase
    endfunction

    function automatic rotated_vec_t rotate_vec(
        input action_t act, input longint vx, input longint vy, input longint vz,
        input logic [ANGLE_WIDTH-1:0] incl, input logic [ANGLE_WIDTH-1:0] raan,
        input logic [ANGLE_WIDTH-1:0] phase);
        longint ci, si, cn, sn, cp, sp, snci, cnci;
        longint rot [3][3];
        longint vin [3];
        logic signed [95:0] acc;
        logic signed [95:0] res [3];
        logic signed [95:0] fin [3];
        rotated_vec_t r;
        sin_cos(incl, ci, si);
        sin_cos(raan, cn, sn);
        sin_cos(phase, cp, sp);
        snci = q30_mul(sn, ci);
        cnci = q30_mul(cn, ci);
        rot[0][0] = q30_mul(cp, cn) - q30_mul(snci, sp);
        rot[0][1] = q30_mul(cp, sn) + q30_mul(cnci, sp);
        rot[0][2] = q30_mul(si, sp);
        rot[1][0] = -q30_mul(sp, cn) - q30_mul(snci, cp);
        rot[1][1] = -q30_mul(sp, sn) + q30_mul(cnci, cp);
        rot[1][2] = q30_mul(si, cp);
        rot[2][0] = q30_mul(si, sn);
        rot[2][1] = -q30_mul(si, cn);
        rot[2][2] = ci;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                rot[a][b] = unit_clip(rot[a][b]);
        // lhlv input axes map back to local before the transpose
        if (act == ACT_FROM_LHLV)
        begin
            vin[0] = -vz; vin[1] = vx; vin[2] = -vy;
        end
        else
        begin
            vin[0] = vx; vin[1] = vy; vin[2] = vz;
        end
        for (int a = 0; a < 3; a++)
        begin
            acc = 0;
            for (int b = 0; b < 3; b++)
                acc += 96'(act[0] ? rot[b][a] : rot[a][b]) * 96'(vin[b]);
            res[a] = (acc + 96'(HALF_Q30)) >>> 30;
        end
        if (act == ACT_TO_LHLV)
        begin
            fin[0] = res[1]; fin[1] = -res[2]; fin[2] = -res[0];
        end
        else
            fin = res;
        r.sat = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (fin[a] > 96'sh7FFFFFFF)
            begin
                fin[a] = 96'sh7FFFFFFF; r.sat = 1'b1;
            end
            if (fin[a] < -96'sh80000000)
            begin
                fin[a] = -96'sh80000000; r.sat = 1'b1;
            end
        end
        r.x = fin[0][VEC_WIDTH-1:0];
        r.y = fin[1][VEC_WIDTH-1:0];
        r.z = fin[2][VEC_WIDTH-1:0];
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    // predict on each accepted item, compare on each result
    always @(posedge clk)
    begin
        rotated_vec_t want;
        if (rst_n)
        begin
            if (start && !busy)
                rotated_q.push_back(rotate_vec(action_t'(action), vec_x, vec_y, vec_z,
                    inclination, node, ANGLE_WIDTH'(periapsis_arg + true_anomaly)));
            if (done)
            begin
                if (rotated_q.size() == 0)
                    report("unexpected result, out_x", out_x, 0);
                else
                begin
                    want = rotated_q.pop_front();
                    if (out_x !== want.x)
                        report("out_x", out_x, want.x);
                    if (out_y !== want.y)
                        report("out_y", out_y, want.y);
                    if (out_z !== want.z)
                        report("out_z", out_z, want.z);
                    if (saturated !== want.sat)
                        report("saturated", saturated, want.sat);
                end
            end
            pending = rotated_q.size();
        end
    end
endmodule
`default_nettype wire

@@ test/tb_orbital_frame_rotation_top.sv @@
// ----------------------------------------------------------------------------
// tb_orbital_frame_rotation_top: testbench for the frame rotation block
// Drives directed corner items and random items with random gaps; the
// checker predicts each rotated vector and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_orbital_frame_rotation_top
    import ofr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done, saturated;
    logic [1:0] action = '0;
    logic signed [VEC_WIDTH-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
    logic [ANGLE_WIDTH-1:0] inclination = '0, node = '0, true_anomaly = '0;
    logic [ANGLE_WIDTH-1:0] periapsis_arg = '0;
    logic signed [VEC_WIDTH-1:0] out_x, out_y, out_z;
    int mismatches, pending;
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    orbital_frame_rotation_top dut (.*);

    ofr_checker checker_i (.*);

    // watchdog on cycles with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [VEC_WIDTH-1:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF - $urandom_range(0, 2);
            1: return -32'sh80000000 + $urandom_range(0, 2);
            2: return $signed($urandom_range(0, 'h3FFFF)) - 'sh20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return ANGLE_WIDTH'(16'h4000 * $urandom_range(0, 3));
            1: return ANGLE_WIDTH'(16'hFFFF - $urandom_range(0, 1));
            default: return ANGLE_WIDTH'($urandom);
        endcase
    endfunction

    // present one item and hold it until accepted
    task automatic send(input action_t act, input logic signed [31:0] x,
                        input logic signed [31:0] y, input logic signed [31:0] z,
                        input logic [15:0] incl, input logic [15:0] raan,
                        input logic [15:0] anom, input logic [15:0] peri);
        action = act; vec_x = x; vec_y = y; vec_z = z;
        inclination = incl; node = raan; true_anomaly = anom; periapsis_arg = peri;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic gap();
        int n;
        case ($urandom_range(0, 19))
            0: n = $urandom_range(15, 40);
            1, 2, 3, 4, 5: n = $urandom_range(1, 4);
            default: n = 0;
        endcase
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: extremes of vectors and angles, every action
        for (int a = 0; a < 4; a++)
        begin
            send(action_t'(a), 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 16'h0, 16'h0, 16'h0, 16'h0);
            send(action_t'(a), -32'sh80000000, -32'sh80000000, -32'sh80000000,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            send(action_t'(a), 32'sh00010000, -32'sh1, 32'sh0,
                 16'h4000, 16'h8000, 16'hC000, 16'h2000);
        end
        // negated minimum through the lhlv inverse
        send(ACT_FROM_LHLV, 32'sh0, -32'sh80000000, -32'sh80000000,
             16'h0, 16'h0, 16'h0, 16'h0);
        send(ACT_FROM_LHLV, -32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000,
             16'h4000, 16'hC000, 16'h8000, 16'h8000);
        // phase wraps past one turn
        send(ACT_TO_LOCAL, 32'sh12345678, -32'sh0ABCDEF0, 32'sh00100000,
             16'h1234, 16'h5678, 16'h0002, 16'hFFFF);
        send(ACT_TO_LHLV, 32'sh00010000, 32'sh00020000, 32'sh00030000,
             16'h2000, 16'hE000, 16'h8001, 16'h8000);

        // random items with random gaps
        for (int i = 0; i < 450; i++)
        begin
            send(action_t'($urandom_range(0, 3)), pick_comp(), pick_comp(), pick_comp(),
                 pick_angle(), pick_angle(), pick_angle(), pick_angle());
            gap();
        end
        start = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
src/ofr_pkg.sv
src/ofr_cordic.sv
src/orbital_frame_rotation_top.sv
test/ofr_checker.sv
test/tb_orbital_frame_rotation_top.sv
